// File: rtl/slotted_page_manager_macros.svh
// Assertion macros for the slotted page manager.
// Included by RTL files that carry concurrent checks; needs a clock and reset in scope.
`ifndef SLOTTED_PAGE_MANAGER_MACROS_SVH
`define SLOTTED_PAGE_MANAGER_MACROS_SVH

// hold cond on every clock edge outside reset
`define SPM_ALWAYS(lbl, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error("slotted page manager check failed");

// when trig holds, cond holds in the next cycle
`define SPM_NEXT(lbl, trig, cond) \
   lbl: assert property (@(posedge clock) disable iff (reset) (trig) |=> (cond)) \
      else $error("slotted page manager sequence check failed");

`endif

// File: rtl/spm_pkg.sv
// Shared constants, codes, types and helpers for the slotted page manager.
// No dependencies.
`default_nettype none
package spm_pkg;
   localparam int PAGE_BYTES   = 4096;
   localparam int MAX_SLOTS    = 1024;
   localparam int HEADER_BYTES = 8;
   localparam int SLOT_BYTES   = 4;

   localparam int PAGE_AW = 12;
   localparam int SLOT_AW = 10;
   localparam int LEN_W   = 13;
   localparam int CNT_W   = 11;

   localparam logic [2:0] OP_CLEAR   = 3'd0;
   localparam logic [2:0] OP_RESERVE = 3'd1;
   localparam logic [2:0] OP_RESIZE  = 3'd2;
   localparam logic [2:0] OP_WRITE   = 3'd3;
   localparam logic [2:0] OP_READ    = 3'd4;
   localparam logic [2:0] OP_DELETE  = 3'd5;
   localparam logic [2:0] OP_NEXT    = 3'd6;
   localparam logic [2:0] OP_COMPACT = 3'd7;

   localparam logic [2:0] ST_OK      = 3'd0;
   localparam logic [2:0] ST_NOSPACE = 3'd1;
   localparam logic [2:0] ST_BADSLOT = 3'd2;
   localparam logic [2:0] ST_TOOLONG = 3'd3;
   localparam logic [2:0] ST_RANGE   = 3'd4;

   typedef struct packed {
      logic             live;
      logic [LEN_W-1:0] offset;
      logic [LEN_W-1:0] length;
   } entry_type;

   function automatic logic [LEN_W-1:0] free_space(input logic [CNT_W-1:0] count,
                                                   input logic [LEN_W-1:0] fs);
      logic [LEN_W+1:0] used;
      logic [LEN_W+1:0] wide;
      used = (LEN_W+2)'(HEADER_BYTES) + (LEN_W+2)'(count) * (LEN_W+2)'(SLOT_BYTES);
      wide = (LEN_W+2)'(fs);
      if (wide > used) return LEN_W'(wide - used);
      return '0;
   endfunction
endpackage
`default_nettype wire

// File: rtl/spm_if.sv
// Request and response channel interfaces for the slotted page manager.
// Depends on nothing; field widths follow the block's item format.
`default_nettype none
interface spm_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [9:0]  slot_index;
   logic [11:0] byte_index;
   logic [12:0] tuple_length;
   logic [7:0]  data_byte;
   modport source (output valid, operation, slot_index, byte_index, tuple_length,
                   data_byte, input ready);
   modport sink (input valid, operation, slot_index, byte_index, tuple_length,
                 data_byte, output ready);
endinterface

interface spm_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  status;
   logic [9:0]  slot_result;
   logic [7:0]  read_byte;
   logic [12:0] length_result;
   logic [12:0] free_bytes;
   logic        found;
   modport source (output valid, status, slot_result, read_byte, length_result,
                   free_bytes, found, input ready);
   modport sink (input valid, status, slot_result, read_byte, length_result,
                 free_bytes, found, output ready);
endinterface
`default_nettype wire

// File: rtl/spm_ram.sv
// Generic simple dual-port synchronous RAM, registered read.
// No dependencies.
`default_nettype none
module spm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int AW = $clog2(DEPTH)
) (
   input  wire logic             clock,
   input  wire logic             we,
   input  wire logic [AW-1:0]    waddr,
   input  wire logic [WIDTH-1:0] wdata,
   input  wire logic [AW-1:0]    raddr,
   output logic      [WIDTH-1:0] rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) mem[waddr] <= wdata;
      rdata <= mem[raddr];
   end
endmodule
`default_nettype wire

// File: rtl/slotted_page_manager.sv
// Slotted page manager top level: control sequencer over directory, page and scratch RAMs.
// Depends on spm_pkg, spm_if, spm_ram and slotted_page_manager_macros.svh.
//
// One page of PAGE_BYTES tuple bytes with a slot directory of up to MAX_SLOTS entries.
// Items are handled one at a time; every item returns one result item. Reserve (when space
// allows) and next occupied walk the directory one entry per cycle. Compact walks the
// directory, copies each live tuple into the scratch RAM packed down from the page top,
// then writes the whole scratch RAM back into the page with bytes below the packed area
// zeroed, one byte at a time through the single read and single write port of each RAM.
// No clearing pass follows reset.
`default_nettype none
`include "slotted_page_manager_macros.svh"
module slotted_page_manager (
   input wire logic clock,
   input wire logic reset,
   spm_req_if.sink   req_chan,
   spm_rsp_if.source rsp_chan
);
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_SCAN  = 4'd1;
   localparam logic [3:0] S_LOOK  = 4'd2;
   localparam logic [3:0] S_RDB   = 4'd3;
   localparam logic [3:0] S_CPDIR = 4'd4;
   localparam logic [3:0] S_CPENT = 4'd5;
   localparam logic [3:0] S_COPY  = 4'd6;
   localparam logic [3:0] S_SWEEP = 4'd7;
   localparam logic [3:0] S_DONE  = 4'd8;

   localparam int LW = spm_pkg::LEN_W;
   localparam int CW = spm_pkg::CNT_W;
   localparam int PW = spm_pkg::PAGE_AW;
   localparam int SW = spm_pkg::SLOT_AW;

   logic [3:0]    state_ff, state_in;
   logic [2:0]    op_ff, op_in;
   logic [SW-1:0] slot_ff, slot_in;
   logic [PW-1:0] bidx_ff, bidx_in;
   logic [LW-1:0] len_ff, len_in;
   logic [7:0]    dbyte_ff, dbyte_in;
   logic [CW-1:0] count_ff, count_in;
   logic [LW-1:0] fs_ff, fs_in;
   logic [LW-1:0] top_ff, top_in;
   logic [LW-1:0] iss_ff, iss_in;
   logic [LW-1:0] idxd_ff, idxd_in;
   logic          pend_ff, pend_in;
   logic [CW-1:0] ci_ff, ci_in;
   logic [LW-1:0] src_ff, src_in;
   logic [LW-1:0] dst_ff, dst_in;
   logic [LW-1:0] clen_ff, clen_in;
   logic [2:0]    rstat_ff, rstat_in;
   logic [SW-1:0] rslot_ff, rslot_in;
   logic [7:0]    rbyte_ff, rbyte_in;
   logic [LW-1:0] rlen_ff, rlen_in;
   logic          rfnd_ff, rfnd_in;

   logic          ovalid_ff, ovalid_in;
   logic [2:0]    ostat_ff, ostat_in;
   logic [SW-1:0] oslot_ff, oslot_in;
   logic [7:0]    obyte_ff, obyte_in;
   logic [LW-1:0] olen_ff, olen_in;
   logic [LW-1:0] ofree_ff, ofree_in;
   logic          ofnd_ff, ofnd_in;

   logic                dir_we;
   logic [SW-1:0]       dir_waddr, dir_raddr;
   spm_pkg::entry_type  dir_wdata, dir_rdata;
   logic                page_we;
   logic [PW-1:0]       page_waddr, page_raddr;
   logic [7:0]          page_wdata, page_rdata;
   logic                scr_we;
   logic [PW-1:0]       scr_waddr, scr_raddr;
   logic [7:0]          scr_wdata, scr_rdata;

   logic          accept;
   logic          out_free;
   logic [LW-1:0] avail;
   logic [LW-1:0] scan_lim;
   logic          scan_target;
   logic [LW:0]   addr_sum;
   logic [LW-1:0] new_top;

   spm_ram #(.WIDTH($bits(spm_pkg::entry_type)), .DEPTH(spm_pkg::MAX_SLOTS)) u_dir (
      .clock(clock), .we(dir_we), .waddr(dir_waddr), .wdata(dir_wdata),
      .raddr(dir_raddr), .rdata(dir_rdata)
   );
   spm_ram #(.WIDTH(8), .DEPTH(spm_pkg::PAGE_BYTES)) u_page (
      .clock(clock), .we(page_we), .waddr(page_waddr), .wdata(page_wdata),
      .raddr(page_raddr), .rdata(page_rdata)
   );
   spm_ram #(.WIDTH(8), .DEPTH(spm_pkg::PAGE_BYTES)) u_scratch (
      .clock(clock), .we(scr_we), .waddr(scr_waddr), .wdata(scr_wdata),
      .raddr(scr_raddr), .rdata(scr_rdata)
   );

   assign req_chan.ready         = (state_ff == S_IDLE);
   assign accept                 = req_chan.valid && req_chan.ready;
   assign out_free               = !ovalid_ff || rsp_chan.ready;
   assign avail                  = spm_pkg::free_space(count_ff, fs_ff);
   assign scan_lim               = LW'(count_ff);
   assign scan_target            = (op_ff == spm_pkg::OP_NEXT);
   assign addr_sum               = (LW+1)'(dir_rdata.offset) + (LW+1)'(bidx_ff);
   assign new_top                = top_ff - dir_rdata.length;

   assign rsp_chan.valid         = ovalid_ff;
   assign rsp_chan.status        = ostat_ff;
   assign rsp_chan.slot_result   = oslot_ff;
   assign rsp_chan.read_byte     = obyte_ff;
   assign rsp_chan.length_result = olen_ff;
   assign rsp_chan.free_bytes    = ofree_ff;
   assign rsp_chan.found         = ofnd_ff;

   always_comb begin
      state_in = state_ff;  op_in = op_ff;      slot_in = slot_ff;   bidx_in = bidx_ff;
      len_in = len_ff;      dbyte_in = dbyte_ff; count_in = count_ff; fs_in = fs_ff;
      top_in = top_ff;      iss_in = iss_ff;    idxd_in = idxd_ff;   pend_in = pend_ff;
      ci_in = ci_ff;        src_in = src_ff;    dst_in = dst_ff;     clen_in = clen_ff;
      rstat_in = rstat_ff;  rslot_in = rslot_ff; rbyte_in = rbyte_ff; rlen_in = rlen_ff;
      rfnd_in = rfnd_ff;
      ovalid_in = ovalid_ff; ostat_in = ostat_ff; oslot_in = oslot_ff; obyte_in = obyte_ff;
      olen_in = olen_ff;    ofree_in = ofree_ff; ofnd_in = ofnd_ff;
      dir_we = 1'b0;  dir_waddr = '0;  dir_wdata = '0;  dir_raddr = '0;
      page_we = 1'b0; page_waddr = '0; page_wdata = '0; page_raddr = '0;
      scr_we = 1'b0;  scr_waddr = '0;  scr_wdata = '0;  scr_raddr = '0;

      if (ovalid_ff && rsp_chan.ready) ovalid_in = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_chan.operation;
               slot_in  = req_chan.slot_index;
               bidx_in  = req_chan.byte_index;
               len_in   = req_chan.tuple_length;
               dbyte_in = req_chan.data_byte;
               rstat_in = spm_pkg::ST_OK;
               rslot_in = '0;
               rbyte_in = '0;
               rlen_in  = '0;
               rfnd_in  = 1'b0;
               pend_in  = 1'b0;
               dir_raddr = req_chan.slot_index;
               unique case (req_chan.operation)
                  spm_pkg::OP_CLEAR: begin
                     count_in = '0;
                     fs_in    = LW'(spm_pkg::PAGE_BYTES);
                     state_in = S_DONE;
                  end
                  spm_pkg::OP_RESERVE: begin
                     if (avail < req_chan.tuple_length) begin
                        rstat_in = spm_pkg::ST_NOSPACE;
                        state_in = S_DONE;
                     end else begin
                        iss_in   = '0;
                        state_in = S_SCAN;
                     end
                  end
                  spm_pkg::OP_NEXT: begin
                     iss_in   = LW'(req_chan.slot_index) + LW'(1);
                     state_in = S_SCAN;
                  end
                  spm_pkg::OP_COMPACT: begin
                     ci_in    = '0;
                     top_in   = LW'(spm_pkg::PAGE_BYTES);
                     state_in = S_CPDIR;
                  end
                  default: begin
                     if (CW'(req_chan.slot_index) >= count_ff) begin
                        rstat_in = spm_pkg::ST_BADSLOT;
                        state_in = S_DONE;
                     end else begin
                        state_in = S_LOOK;
                     end
                  end
               endcase
            end
         end
         S_SCAN: begin
            if (iss_ff < scan_lim) begin
               dir_raddr = iss_ff[SW-1:0];
               iss_in    = iss_ff + LW'(1);
               idxd_in   = iss_ff;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff && dir_rdata.live == scan_target) begin
               pend_in  = 1'b0;
               state_in = S_DONE;
               if (scan_target) begin
                  rfnd_in  = 1'b1;
                  rslot_in = idxd_ff[SW-1:0];
                  rlen_in  = dir_rdata.length;
               end else begin
                  dir_we    = 1'b1;
                  dir_waddr = idxd_ff[SW-1:0];
                  dir_wdata = '{live: 1'b1, offset: fs_ff - len_ff, length: len_ff};
                  fs_in     = fs_ff - len_ff;
                  rslot_in  = idxd_ff[SW-1:0];
                  rlen_in   = len_ff;
               end
            end else if (!pend_ff && iss_ff >= scan_lim) begin
               state_in = S_DONE;
               if (!scan_target) begin
                  if (avail - len_ff < LW'(spm_pkg::SLOT_BYTES) ||
                      count_ff >= CW'(spm_pkg::MAX_SLOTS)) begin
                     rstat_in = spm_pkg::ST_NOSPACE;
                  end else begin
                     dir_we    = 1'b1;
                     dir_waddr = count_ff[SW-1:0];
                     dir_wdata = '{live: 1'b1, offset: fs_ff - len_ff, length: len_ff};
                     fs_in     = fs_ff - len_ff;
                     count_in  = count_ff + CW'(1);
                     rslot_in  = count_ff[SW-1:0];
                     rlen_in   = len_ff;
                  end
               end
            end
         end
         S_LOOK: begin
            state_in = S_DONE;
            if (!dir_rdata.live) begin
               rstat_in = spm_pkg::ST_BADSLOT;
            end else begin
               case (op_ff)
                  spm_pkg::OP_RESIZE: begin
                     if (len_ff > dir_rdata.length) begin
                        rstat_in = spm_pkg::ST_TOOLONG;
                     end else begin
                        dir_we    = 1'b1;
                        dir_waddr = slot_ff;
                        dir_wdata = '{live: 1'b1, offset: dir_rdata.offset, length: len_ff};
                        rlen_in   = len_ff;
                     end
                  end
                  spm_pkg::OP_WRITE, spm_pkg::OP_READ: begin
                     rlen_in = dir_rdata.length;
                     if (LW'(bidx_ff) >= dir_rdata.length) begin
                        rstat_in = spm_pkg::ST_RANGE;
                     end else if (op_ff == spm_pkg::OP_WRITE) begin
                        page_we    = 1'b1;
                        page_waddr = addr_sum[PW-1:0];
                        page_wdata = dbyte_ff;
                     end else begin
                        page_raddr = addr_sum[PW-1:0];
                        state_in   = S_RDB;
                     end
                  end
                  default: begin
                     dir_we    = 1'b1;
                     dir_waddr = slot_ff;
                     dir_wdata = '{live: 1'b0, offset: dir_rdata.offset,
                                   length: dir_rdata.length};
                  end
               endcase
            end
         end
         S_RDB: begin
            rbyte_in = page_rdata;
            state_in = S_DONE;
         end
         S_CPDIR: begin
            if (ci_ff < count_ff) begin
               dir_raddr = ci_ff[SW-1:0];
               state_in  = S_CPENT;
            end else begin
               iss_in   = '0;
               pend_in  = 1'b0;
               state_in = S_SWEEP;
            end
         end
         S_CPENT: begin
            if (!dir_rdata.live) begin
               ci_in    = ci_ff + CW'(1);
               state_in = S_CPDIR;
            end else begin
               top_in    = new_top;
               dir_we    = 1'b1;
               dir_waddr = ci_ff[SW-1:0];
               dir_wdata = '{live: 1'b1, offset: new_top, length: dir_rdata.length};
               src_in    = dir_rdata.offset;
               dst_in    = new_top;
               clen_in   = dir_rdata.length;
               iss_in    = '0;
               pend_in   = 1'b0;
               state_in  = S_COPY;
            end
         end
         S_COPY: begin
            if (iss_ff < clen_ff) begin
               page_raddr = PW'(src_ff + iss_ff);
               iss_in     = iss_ff + LW'(1);
               idxd_in    = iss_ff;
               pend_in    = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               scr_we    = 1'b1;
               scr_waddr = PW'(dst_ff + idxd_ff);
               scr_wdata = page_rdata;
            end else if (iss_ff >= clen_ff) begin
               ci_in    = ci_ff + CW'(1);
               state_in = S_CPDIR;
            end
         end
         S_SWEEP: begin
            if (iss_ff < LW'(spm_pkg::PAGE_BYTES)) begin
               scr_raddr = iss_ff[PW-1:0];
               iss_in    = iss_ff + LW'(1);
               idxd_in   = iss_ff;
               pend_in   = 1'b1;
            end else begin
               pend_in = 1'b0;
            end
            if (pend_ff) begin
               page_we    = 1'b1;
               page_waddr = idxd_ff[PW-1:0];
               page_wdata = (idxd_ff >= top_ff) ? scr_rdata : 8'd0;
            end else if (iss_ff >= LW'(spm_pkg::PAGE_BYTES)) begin
               fs_in    = top_ff;
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               ovalid_in = 1'b1;
               ostat_in  = rstat_ff;
               oslot_in  = rslot_ff;
               obyte_in  = rbyte_ff;
               olen_in   = rlen_ff;
               ofree_in  = avail;
               ofnd_in   = rfnd_ff;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         fs_ff     <= LW'(spm_pkg::PAGE_BYTES);
         pend_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         fs_ff     <= fs_in;
         pend_ff   <= pend_in;
         ovalid_ff <= ovalid_in;
      end
      op_ff    <= op_in;    slot_ff  <= slot_in;  bidx_ff  <= bidx_in;  len_ff   <= len_in;
      dbyte_ff <= dbyte_in; top_ff   <= top_in;   iss_ff   <= iss_in;   idxd_ff  <= idxd_in;
      ci_ff    <= ci_in;    src_ff   <= src_in;   dst_ff   <= dst_in;   clen_ff  <= clen_in;
      rstat_ff <= rstat_in; rslot_ff <= rslot_in; rbyte_ff <= rbyte_in; rlen_ff  <= rlen_in;
      rfnd_ff  <= rfnd_in;
      ostat_ff <= ostat_in; oslot_ff <= oslot_in; obyte_ff <= obyte_in; olen_ff  <= olen_in;
      ofree_ff <= ofree_in; ofnd_ff  <= ofnd_in;
   end

   `SPM_ALWAYS(a_count_bound, count_ff <= CW'(spm_pkg::MAX_SLOTS))
   `SPM_ALWAYS(a_free_bound, fs_ff <= LW'(spm_pkg::PAGE_BYTES))
   `SPM_ALWAYS(a_idle_no_page_write, !(state_ff == S_IDLE && page_we))
   `SPM_NEXT(a_done_loads_out, state_ff == S_DONE && out_free, ovalid_ff && state_ff == S_IDLE)
endmodule
`default_nettype wire

// File: tb/sv/spm_page_checker.sv
// Page checker: watches the request and response channels of the slotted page manager,
// predicts each response from its own copy of the page state and compares every field.
// Depends on spm_pkg and spm_if.
`default_nettype none
module spm_page_checker (
   input wire logic clock,
   input wire logic reset,
   spm_req_if.sink  req_mon,
   spm_rsp_if.sink  rsp_mon,
   output int       fail_count,
   output int       pending_count
);
   typedef struct packed {
      logic [2:0]  status;
      logic [9:0]  slot_result;
      logic [7:0]  read_byte;
      logic [12:0] length_result;
      logic [12:0] free_bytes;
      logic        found;
   } page_answer_type;

   logic [7:0]  page_mem [spm_pkg::PAGE_BYTES];
   int          tup_off [spm_pkg::MAX_SLOTS];
   int          tup_len [spm_pkg::MAX_SLOTS];
   bit          tup_live [spm_pkg::MAX_SLOTS];
   int          dir_count;
   int          low_used;
   page_answer_type answer_q [$];

   function automatic int room_left();
      int used;
      used = spm_pkg::HEADER_BYTES + dir_count * spm_pkg::SLOT_BYTES;
      return low_used > used ? low_used - used : 0;
   endfunction

   function automatic bit slot_usable(int s);
      return s < dir_count && tup_live[s];
   endfunction

   function automatic void repack_page();
      logic [7:0] packed_mem [spm_pkg::PAGE_BYTES];
      int top;
      top = spm_pkg::PAGE_BYTES;
      foreach (packed_mem[k]) packed_mem[k] = 8'd0;
      for (int i = 0; i < dir_count; i++) begin
         if (!tup_live[i]) begin
            tup_len[i] = 0;
            continue;
         end
         if (tup_len[i] > top) tup_len[i] = top;
         top -= tup_len[i];
         for (int k = 0; k < tup_len[i]; k++)
            packed_mem[top + k] = (tup_off[i] + k < spm_pkg::PAGE_BYTES) ?
                                  page_mem[tup_off[i] + k] : 8'd0;
         tup_off[i] = top;
      end
      page_mem = packed_mem;
      low_used = top;
   endfunction

   function automatic page_answer_type apply_operation(logic [2:0] op, int slot, int bidx,
                                                       int len, logic [7:0] dbyte);
      page_answer_type a;
      int avail;
      int pick;
      a = '0;
      case (op)
         spm_pkg::OP_CLEAR: begin
            foreach (tup_live[i]) tup_live[i] = 0;
            dir_count = 0;
            low_used = spm_pkg::PAGE_BYTES;
         end
         spm_pkg::OP_RESERVE: begin
            avail = room_left();
            pick = -1;
            if (avail < len) a.status = spm_pkg::ST_NOSPACE;
            else begin
               for (int i = 0; i < dir_count; i++)
                  if (!tup_live[i]) begin
                     pick = i;
                     break;
                  end
               if (pick < 0) begin
                  if (avail - len < spm_pkg::SLOT_BYTES || dir_count >= spm_pkg::MAX_SLOTS)
                     a.status = spm_pkg::ST_NOSPACE;
                  else begin
                     pick = dir_count;
                     dir_count++;
                  end
               end
               if (pick >= 0) begin
                  tup_len[pick] = len;
                  tup_off[pick] = low_used - len;
                  tup_live[pick] = 1;
                  low_used = low_used - len;
                  a.slot_result = pick;
                  a.length_result = len;
               end
            end
         end
         spm_pkg::OP_RESIZE: begin
            if (!slot_usable(slot)) a.status = spm_pkg::ST_BADSLOT;
            else if (len > tup_len[slot]) a.status = spm_pkg::ST_TOOLONG;
            else begin
               tup_len[slot] = len;
               a.length_result = len;
            end
         end
         spm_pkg::OP_WRITE, spm_pkg::OP_READ: begin
            if (!slot_usable(slot)) a.status = spm_pkg::ST_BADSLOT;
            else begin
               a.length_result = tup_len[slot];
               if (bidx >= tup_len[slot]) a.status = spm_pkg::ST_RANGE;
               else if (tup_off[slot] + bidx < spm_pkg::PAGE_BYTES) begin
                  if (op == spm_pkg::OP_WRITE) page_mem[tup_off[slot] + bidx] = dbyte;
                  else a.read_byte = page_mem[tup_off[slot] + bidx];
               end
            end
         end
         spm_pkg::OP_DELETE: begin
            if (!slot_usable(slot)) a.status = spm_pkg::ST_BADSLOT;
            else tup_live[slot] = 0;
         end
         spm_pkg::OP_NEXT: begin
            for (int i = slot + 1; i < dir_count; i++)
               if (tup_live[i]) begin
                  a.found = 1'b1;
                  a.slot_result = i;
                  a.length_result = tup_len[i];
                  break;
               end
         end
         default: repack_page();
      endcase
      a.free_bytes = room_left();
      return a;
   endfunction

   page_answer_type got, want, next_answer;
   int mismatch_count;

   always @(posedge clock) begin
      if (reset) begin
         foreach (tup_live[i]) tup_live[i] = 0;
         foreach (page_mem[i]) page_mem[i] = 8'd0;
         dir_count = 0;
         low_used = spm_pkg::PAGE_BYTES;
         answer_q.delete();
         fail_count = 0;
         mismatch_count = 0;
      end else begin
         if (rsp_mon.valid && rsp_mon.ready) begin
            got = {rsp_mon.status, rsp_mon.slot_result, rsp_mon.read_byte,
                   rsp_mon.length_result, rsp_mon.free_bytes, rsp_mon.found};
            if (answer_q.size() == 0) begin
               fail_count++;
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response item: %p", got);
            end else begin
               want = answer_q.pop_front();
               if (got !== want) begin
                  fail_count++;
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display("response mismatch: expected %p actual %p", want, got);
               end
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            next_answer = apply_operation(req_mon.operation, req_mon.slot_index,
                                          req_mon.byte_index, req_mon.tuple_length,
                                          req_mon.data_byte);
            answer_q = {answer_q, next_answer};
         end
      end
      pending_count = answer_q.size();
   end
endmodule
`default_nettype wire

// File: tb/sv/slotted_page_manager_test.sv
// Testbench top for the slotted page manager: drives page operations with random idling
// and back-pressure; spm_page_checker predicts and compares. Depends on spm_pkg, spm_if.
`default_nettype none
module slotted_page_manager_test;
   logic clock = 1'b0;
   logic reset = 1'b1;
   int   fail_count;
   int   pending_count;
   int   cycle_count = 0;
   bit   calm = 0;
   int   sent_count = 0;
   int   write_count = 0;

   spm_req_if req_chan ();
   spm_rsp_if rsp_chan ();

   slotted_page_manager i_dut (.clock(clock), .reset(reset), .req_chan(req_chan.sink),
                               .rsp_chan(rsp_chan.source));
   spm_page_checker i_checker (.clock(clock), .reset(reset), .req_mon(req_chan.sink),
                               .rsp_mon(rsp_chan.sink), .fail_count(fail_count),
                               .pending_count(pending_count));

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > 3000000) begin
         $display("tb: failure");
         $finish;
      end
   end

   // random back-pressure bursts on the response side
   int stall_left = 0;
   always @(negedge clock) begin
      if (calm || reset) rsp_chan.ready <= 1'b1;
      else if (stall_left > 0) begin
         stall_left--;
         rsp_chan.ready <= 1'b0;
      end else if ($urandom_range(0, 7) == 0) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_chan.ready <= 1'b0;
      end else rsp_chan.ready <= 1'b1;
   end

   // mirror of which bytes were written, so reads touch only written bytes
   bit written [spm_pkg::PAGE_BYTES];
   int m_off [spm_pkg::MAX_SLOTS];
   int m_len [spm_pkg::MAX_SLOTS];
   bit m_live [spm_pkg::MAX_SLOTS];
   int m_count = 0;
   int m_low = spm_pkg::PAGE_BYTES;

   function automatic bit byte_known(int s, int b);
      return m_off[s] + b < spm_pkg::PAGE_BYTES && written[m_off[s] + b];
   endfunction

   function automatic void track(logic [2:0] op, int s, int b, int len);
      int avail, pick;
      bit w2 [spm_pkg::PAGE_BYTES];
      int top;
      case (op)
         spm_pkg::OP_CLEAR: begin
            foreach (m_live[i]) m_live[i] = 0;
            m_count = 0;
            m_low = spm_pkg::PAGE_BYTES;
         end
         spm_pkg::OP_RESERVE: begin
            avail = m_low > spm_pkg::HEADER_BYTES + m_count * spm_pkg::SLOT_BYTES ?
                    m_low - spm_pkg::HEADER_BYTES - m_count * spm_pkg::SLOT_BYTES : 0;
            pick = -1;
            if (avail >= len) begin
               for (int i = 0; i < m_count; i++)
                  if (!m_live[i]) begin pick = i; break; end
               if (pick < 0 && avail - len >= spm_pkg::SLOT_BYTES &&
                   m_count < spm_pkg::MAX_SLOTS) begin
                  pick = m_count;
                  m_count++;
               end
               if (pick >= 0) begin
                  m_len[pick] = len;
                  m_off[pick] = m_low - len;
                  m_live[pick] = 1;
                  m_low -= len;
               end
            end
         end
         spm_pkg::OP_RESIZE: if (s < m_count && m_live[s] && len <= m_len[s]) m_len[s] = len;
         spm_pkg::OP_WRITE:
            if (s < m_count && m_live[s] && b < m_len[s] &&
                m_off[s] + b < spm_pkg::PAGE_BYTES)
               written[m_off[s] + b] = 1;
         spm_pkg::OP_DELETE: if (s < m_count && m_live[s]) m_live[s] = 0;
         spm_pkg::OP_COMPACT: begin
            top = spm_pkg::PAGE_BYTES;
            foreach (w2[k]) w2[k] = 1;
            for (int i = 0; i < m_count; i++) begin
               if (!m_live[i]) begin m_len[i] = 0; continue; end
               if (m_len[i] > top) m_len[i] = top;
               top -= m_len[i];
               for (int k = 0; k < m_len[i]; k++)
                  w2[top + k] = m_off[i] + k < spm_pkg::PAGE_BYTES ?
                                written[m_off[i] + k] : 1;
               m_off[i] = top;
            end
            written = w2;
            m_low = top;
         end
         default: ;
      endcase
   endfunction

   task automatic send_item(logic [2:0] op, int s, int b, int len, int d);
      int gap;
      s = s & 1023;
      if (!calm && $urandom_range(0, 5) == 0) begin
         gap = $urandom_range(1, 19);
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      // never read a byte nobody wrote
      if (op == spm_pkg::OP_READ && m_live[s[9:0]] && s < m_count && b < m_len[s] &&
          !byte_known(s, b))
         op = spm_pkg::OP_WRITE;
      req_chan.operation    <= op;
      req_chan.slot_index   <= s[9:0];
      req_chan.byte_index   <= b[11:0];
      req_chan.tuple_length <= len[12:0];
      req_chan.data_byte    <= d[7:0];
      req_chan.valid        <= 1'b1;
      track(op, s, b, len);
      if (op == spm_pkg::OP_WRITE) write_count++;
      sent_count++;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   function automatic int live_slot();
      for (int t = 0; t < 8; t++) begin
         int s;
         s = $urandom_range(0, m_count > 0 ? m_count - 1 : 0);
         if (m_live[s]) return s;
      end
      return $urandom_range(0, m_count + 2);
   endfunction

   int s, b, len;
   initial begin
      req_chan.valid = 1'b0;
      req_chan.operation = spm_pkg::OP_CLEAR;
      req_chan.slot_index = '0;
      req_chan.byte_index = '0;
      req_chan.tuple_length = '0;
      req_chan.data_byte = '0;
      rsp_chan.ready = 1'b1;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: extremes and each special case
      send_item(spm_pkg::OP_RESERVE, 0, 0, 4096, 0);
      send_item(spm_pkg::OP_RESERVE, 0, 0, 4084, 0);
      send_item(spm_pkg::OP_CLEAR, 0, 0, 0, 0);
      send_item(spm_pkg::OP_RESERVE, 0, 0, 4083, 0);
      send_item(spm_pkg::OP_WRITE, 0, 4082, 0, 255);
      send_item(spm_pkg::OP_READ, 0, 4082, 0, 0);
      send_item(spm_pkg::OP_WRITE, 0, 4083, 0, 1);
      send_item(spm_pkg::OP_READ, 0, 4095, 0, 0);
      send_item(spm_pkg::OP_RESERVE, 0, 0, 0, 0);
      send_item(spm_pkg::OP_CLEAR, 0, 0, 0, 0);
      send_item(spm_pkg::OP_RESERVE, 0, 0, 3, 0);
      send_item(spm_pkg::OP_RESERVE, 0, 0, 5, 0);
      send_item(spm_pkg::OP_WRITE, 1, 0, 0, 8'hA5);
      send_item(spm_pkg::OP_RESIZE, 1, 0, 6, 0);
      send_item(spm_pkg::OP_RESIZE, 1, 0, 2, 0);
      send_item(spm_pkg::OP_RESIZE, 1023, 0, 0, 0);
      send_item(spm_pkg::OP_DELETE, 0, 0, 0, 0);
      send_item(spm_pkg::OP_DELETE, 0, 0, 0, 0);
      send_item(spm_pkg::OP_WRITE, 0, 0, 0, 7);
      send_item(spm_pkg::OP_NEXT, 0, 0, 0, 0);
      send_item(spm_pkg::OP_NEXT, 1023, 0, 0, 0);
      send_item(spm_pkg::OP_RESERVE, 0, 0, 4, 0);
      send_item(spm_pkg::OP_COMPACT, 0, 0, 0, 0);
      send_item(spm_pkg::OP_READ, 1, 0, 0, 0);
      send_item(spm_pkg::OP_READ, 1023, 4095, 0, 0);

      // random: mostly small tuples on few slots, occasional large values and compaction
      for (int n = 0; n < 400; n++) begin
         int r;
         if (n == 340) calm = 1;
         r = $urandom_range(0, 99);
         s = live_slot();
         len = $urandom_range(0, 40);
         if ($urandom_range(0, 19) == 0) len = $urandom_range(0, 8191);
         b = (s < m_count && m_live[s] && m_len[s] > 0) ? $urandom_range(0, m_len[s] - 1) : 0;
         if ($urandom_range(0, 9) == 0) b = $urandom_range(0, 4095);
         if ($urandom_range(0, 15) == 0) s = $urandom_range(0, 1023);
         if (r < 2) send_item(spm_pkg::OP_CLEAR, s, b, len, $urandom);
         else if (r < 22) send_item(spm_pkg::OP_RESERVE, s, b, len, $urandom);
         else if (r < 30) send_item(spm_pkg::OP_RESIZE, s, b, $urandom_range(0, 20), $urandom);
         else if (r < 58) send_item(spm_pkg::OP_WRITE, s, b, len, $urandom);
         else if (r < 80) send_item(spm_pkg::OP_READ, s, b, len, $urandom);
         else if (r < 88) send_item(spm_pkg::OP_DELETE, s, b, len, $urandom);
         else if (r < 96) send_item(spm_pkg::OP_NEXT,
                                    $urandom_range(0, 1) ? s : $urandom_range(0, 1023),
                                    b, len, $urandom);
         else send_item(spm_pkg::OP_COMPACT, s, b, len, $urandom);
      end
      req_chan.valid <= 1'b0;

      while (pending_count != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("run covered %0d items, %0d byte writes, all eight operations", sent_count,
               write_count);
      if (fail_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire

// File: slotted_page_manager.f
+incdir+rtl
rtl/spm_pkg.sv
rtl/spm_if.sv
rtl/spm_ram.sv
rtl/slotted_page_manager.sv
tb/sv/spm_page_checker.sv
tb/sv/slotted_page_manager_test.sv
